// ----- src/awfpa_pkg.sv -----
// Package for the area-weighted face-to-point average block.
// Holds the word types, field widths, action and status codes and the store size.
// No dependencies.
`timescale 1ns / 1ps

package awfpa_pkg;

  // Store size and field widths
  localparam int unsigned POINT_COUNT = 4096;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned DIST_W      = 24;
  localparam int unsigned FACE_A_W    = 24;
  localparam int unsigned AREA_W      = 40;
  localparam int unsigned WSUM_W      = 64;
  localparam int unsigned PROD_W      = FACE_A_W + DIST_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIST_W);

  // Number of points as an index-sized-plus-one value for the range check
  localparam logic [IDX_W:0] POINT_LIMIT = (IDX_W + 1)'(POINT_COUNT);

  // Action codes
  localparam logic [1:0] ACT_ACCUM = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ZERO_AREA   = 3'd1;
  localparam logic [2:0] ST_ZERO_DIST   = 3'd2;
  localparam logic [2:0] ST_UNCONNECTED = 3'd3;
  localparam logic [2:0] ST_SATURATED   = 3'd4;

  typedef struct packed {
    logic [1:0]          action;
    logic [IDX_W-1:0]    point_index;
    logic [FACE_A_W-1:0] face_area;
    logic [DIST_W-1:0]   face_distance;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DIST_W-1:0] point_distance;
    logic [AREA_W-1:0] point_area;
  } out_word_t;

endpackage

// ----- src/area_weighted_face_to_point_average.sv -----
// Area-weighted face-to-point average: top level.
// Uses awfpa_pkg for the word types, widths and codes.
// Holds the two per-point sum memories, the accumulate datapath and the divider.
`timescale 1ns / 1ps

// Usage
//   Input words arrive on in_word_i with in_valid_i; a word is taken at a clock
//   edge where in_valid_i is high and in_stall_o is low. Each word produces
//   exactly one result word on out_word_o with out_valid_o; the receiver holds
//   it with out_stall_i and the result waits in the output register.
//   Accumulate, clear and unused actions: result registered from S_READ, the
//   state after the word is taken; next word taken back in S_IDLE (one memory
//   read-modify-write per word through the synchronous sum memories).
//   Read of an unconnected or clamped point: same timing. Any other read:
//   result registered when the S_DIV steps after S_READ end, next word taken
//   after that; the restoring divider yields one quotient bit per cycle.
//   A new word is taken while the previous result still waits, as long as
//   the output register drains at that edge.
//   Reset: after rst_ni is released the block sweeps both memories to zero,
//   one entry per cycle, through all POINT_COUNT (4096) entries; in_stall_o
//   stays high during that pass.
//   A stalled receiver holds the result; no new word is taken until the
//   output register frees up.
module area_weighted_face_to_point_average (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  awfpa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output awfpa_pkg::out_word_t out_word_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  // Control state
  logic [1:0]                          state_q, state_d;
  logic [awfpa_pkg::IDX_W-1:0]         clr_cnt_q, clr_cnt_d;
  logic [awfpa_pkg::DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic                                out_valid_q;

  // Payload state
  awfpa_pkg::in_word_t                 item_q;
  logic [awfpa_pkg::PROD_W-1:0]        prod_q;
  logic [awfpa_pkg::AREA_W-1:0]        rem_q, rem_d;
  logic [awfpa_pkg::DIST_W-1:0]        quo_q, quo_d;
  logic [awfpa_pkg::AREA_W-1:0]        div_as_q, div_as_d;
  awfpa_pkg::out_word_t                out_q, out_d;

  // Memories and their ports
  logic [awfpa_pkg::WSUM_W-1:0]        ws_mem [awfpa_pkg::POINT_COUNT];
  logic [awfpa_pkg::AREA_W-1:0]        as_mem [awfpa_pkg::POINT_COUNT];
  logic [awfpa_pkg::WSUM_W-1:0]        ws_rd_q;
  logic [awfpa_pkg::AREA_W-1:0]        as_rd_q;
  logic                                mem_we;
  logic [awfpa_pkg::IDX_W-1:0]         mem_waddr;
  logic [awfpa_pkg::WSUM_W-1:0]        ws_wdata;
  logic [awfpa_pkg::AREA_W-1:0]        as_wdata;

  // Datapath signals
  logic                                in_accept;
  logic                                out_load;
  logic                                idx_ok;
  logic [awfpa_pkg::WSUM_W:0]          ws_sum;
  logic [awfpa_pkg::AREA_W:0]          as_sum;
  logic                                sat;
  logic [awfpa_pkg::AREA_W:0]          trial;
  logic [awfpa_pkg::AREA_W:0]          trial_diff;
  logic                                trial_ge;

  // Take a word only when idle and the output register is free or draining
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Range check on the addressed point
  assign idx_ok = ({1'b0, item_q.point_index} < awfpa_pkg::POINT_LIMIT);

  // Saturating sums for accumulate
  assign ws_sum = {1'b0, ws_rd_q}
                + {(awfpa_pkg::WSUM_W + 1 - awfpa_pkg::PROD_W)'(0), prod_q};
  assign as_sum = {1'b0, as_rd_q}
                + {(awfpa_pkg::AREA_W + 1 - awfpa_pkg::FACE_A_W)'(0), item_q.face_area};
  assign sat    = ws_sum[awfpa_pkg::WSUM_W] || as_sum[awfpa_pkg::AREA_W];

  // One restoring division step
  assign trial      = {rem_q, quo_q[awfpa_pkg::DIST_W-1]};
  assign trial_ge   = (trial >= {1'b0, div_as_q});
  assign trial_diff = trial - {1'b0, div_as_q};

  // Sequence the item and build the result
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    div_cnt_d = div_cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    div_as_d  = div_as_q;
    out_load  = 1'b0;
    out_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = item_q.point_index;
    ws_wdata  = '0;
    as_wdata  = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == awfpa_pkg::IDX_W'(awfpa_pkg::POINT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d  = S_IDLE;
        out_load = 1'b1;
        if (!idx_ok) begin
          out_d.status = awfpa_pkg::ST_UNCONNECTED;
        end else begin
          case (item_q.action)
            awfpa_pkg::ACT_ACCUM: begin
              out_d.point_area = as_rd_q;
              if (item_q.face_area == '0) begin
                out_d.status = awfpa_pkg::ST_ZERO_AREA;
              end else if (item_q.face_distance == '0) begin
                out_d.status = awfpa_pkg::ST_ZERO_DIST;
              end else begin
                mem_we   = 1'b1;
                ws_wdata = ws_sum[awfpa_pkg::WSUM_W] ? '1 : ws_sum[awfpa_pkg::WSUM_W-1:0];
                as_wdata = as_sum[awfpa_pkg::AREA_W] ? '1 : as_sum[awfpa_pkg::AREA_W-1:0];
                out_d.point_area = as_wdata;
                out_d.status     = sat ? awfpa_pkg::ST_SATURATED : awfpa_pkg::ST_OK;
              end
            end
            awfpa_pkg::ACT_READ: begin
              if (as_rd_q == '0) begin
                out_d.status = awfpa_pkg::ST_UNCONNECTED;
              end else if (ws_rd_q[awfpa_pkg::WSUM_W-1:awfpa_pkg::DIST_W] >= as_rd_q) begin
                // Quotient does not fit the distance field: clamp
                out_d.status         = awfpa_pkg::ST_OK;
                out_d.point_distance = '1;
                out_d.point_area     = as_rd_q;
              end else begin
                // Upper part is below the divisor: 24 steps finish the quotient
                out_load  = 1'b0;
                rem_d     = ws_rd_q[awfpa_pkg::WSUM_W-1:awfpa_pkg::DIST_W];
                quo_d     = ws_rd_q[awfpa_pkg::DIST_W-1:0];
                div_as_d  = as_rd_q;
                div_cnt_d = awfpa_pkg::DIV_CNT_W'(awfpa_pkg::DIST_W - 1);
                state_d   = S_DIV;
              end
            end
            awfpa_pkg::ACT_CLEAR: begin
              mem_we       = 1'b1;
              out_d.status = awfpa_pkg::ST_OK;
            end
            default: begin
              out_d.status     = awfpa_pkg::ST_OK;
              out_d.point_area = as_rd_q;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_d     = trial_ge ? trial_diff[awfpa_pkg::AREA_W-1:0] : trial[awfpa_pkg::AREA_W-1:0];
        quo_d     = {quo_q[awfpa_pkg::DIST_W-2:0], trial_ge};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d              = S_IDLE;
          out_load             = 1'b1;
          out_d.status         = awfpa_pkg::ST_OK;
          out_d.point_distance = quo_d;
          out_d.point_area     = div_as_q;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      div_cnt_q <= div_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the word, its product and the divider state
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_word_i;
      prod_q <= {(awfpa_pkg::PROD_W - awfpa_pkg::FACE_A_W)'(0), in_word_i.face_area}
              * {(awfpa_pkg::PROD_W - awfpa_pkg::DIST_W)'(0), in_word_i.face_distance};
    end
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    div_as_q <= div_as_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Sum memories: one write port, registered read on accept
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ws_mem[mem_waddr] <= ws_wdata;
      as_mem[mem_waddr] <= as_wdata;
    end
    if (in_accept) begin
      ws_rd_q <= ws_mem[in_word_i.point_index];
      as_rd_q <= as_mem[in_word_i.point_index];
    end
  end

`ifndef SYNTHESIS
  // The output register is free whenever a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |-> !out_valid_q)
    else $error("result loaded over a waiting word");

  // No word is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_CLEAR) |-> in_stall_o)
    else $error("word taken while clearing the store");

  // A taken word is processed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> (state_q == S_READ))
    else $error("accepted word not processed");

  // Only a read yields a nonzero mean distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_load && (item_q.action != awfpa_pkg::ACT_READ))
                   |-> (out_d.point_distance == '0))
    else $error("distance reported for a non-read word");
`endif

endmodule
